>>> sv/gdfo_pkg.sv
// Package for the depth-first order block: field widths, opcodes, sequencer states.
// No dependencies; every other file of the block imports it.
package gdfo_pkg;

  localparam int VERTEX_W = 6;
  localparam int ROW_W = 64;
  localparam int COUNT_W = 7;
  localparam int DEF_MAX_VERTICES = 64;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_START = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PICK,
    ST_POP
  } state_t;

endpackage

>>> sv/graph_depth_first_order.sv
// Depth-first visit order over an adjacency bit matrix held in block RAM.
// Depends on gdfo_pkg (widths, opcodes, sequencer states).
//
// Use:
//   Requests enter on item_valid / item_stall. A load request (opcode load) writes
//   row_index's adjacency row and is taken every cycle while the block is idle.
//   A start request walks the graph from start_vertex and returns one result per
//   reachable vertex in recursive depth-first order (lowest neighbor first). The
//   final result carries last. A start at or above the vertex count returns one
//   result with bad_start and last set.
//   Results leave on result_valid / result_stall from an output register; while
//   the receiver stalls, the walk holds in place and resumes when the slot frees.
//   cfg_we / cfg_wdata write vertex_count; write it only while idle.
// Walk steps:
//   Each visited vertex passes a row read and a lowest-neighbor pick; each
//   backtrack level an empty pick and a stack read that refetches the parent row.
//   Results lag one step so last can be marked: the first is loaded at the first
//   pick after the start. Requests wait out the whole walk.
// Reset:
//   rst clears control, the visited map and the stack depth, and sets vertex_count
//   to 64. Adjacency rows are undefined until loaded.
module graph_depth_first_order #(
  parameter int MAX_VERTICES = gdfo_pkg::DEF_MAX_VERTICES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           opcode,
  input  logic [gdfo_pkg::VERTEX_W-1:0]  row_index,
  input  logic [gdfo_pkg::ROW_W-1:0]     row_bits,
  input  logic [gdfo_pkg::VERTEX_W-1:0]  start_vertex,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [gdfo_pkg::VERTEX_W-1:0]  visited_vertex,
  output logic                           last,
  output logic                           bad_start,
  input  logic                           cfg_we,
  input  logic [gdfo_pkg::COUNT_W-1:0]   cfg_wdata
);
  import gdfo_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DW = AW + 1;
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_VERTICES);
  localparam logic [DW-1:0] MAX_DEPTH = DW'(MAX_VERTICES);

  // Storage
  logic [ROW_W-1:0]    adj_mem [MAX_VERTICES];
  logic [VERTEX_W-1:0] stack_mem [MAX_VERTICES];
  logic [ROW_W-1:0]    adj_q;
  logic [VERTEX_W-1:0] stack_q;

  // Control and datapath registers
  state_t              state, state_next;
  logic [COUNT_W-1:0]  vertex_count;
  logic [ROW_W-1:0]    visited, visited_next;
  logic [ROW_W-1:0]    mask_q, mask_next;
  logic [DW-1:0]       depth, depth_next;
  logic [VERTEX_W-1:0] top, top_next;
  logic [VERTEX_W-1:0] pending, pending_next;

  // Strobes
  logic                item_take;
  logic                out_free;
  logic                out_load;
  logic [VERTEX_W-1:0] out_vertex;
  logic                out_last;
  logic                out_bad;
  logic                adj_we, adj_re, stack_we, stack_re;
  logic [AW-1:0]       adj_waddr, adj_raddr, stack_waddr, stack_raddr;
  logic [DW-1:0]       depth_m2;

  logic [COUNT_W-1:0]  eff_count;
  logic                start_bad;
  logic [ROW_W-1:0]    cand;
  logic                found;
  logic [VERTEX_W-1:0] pick;

  assign out_free  = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE) ||
                      ((opcode == OP_START) && !out_free);
  assign item_take = item_valid && !item_stall;

  assign eff_count = (vertex_count > MAX_COUNT) ? MAX_COUNT : vertex_count;
  assign start_bad = {1'b0, start_vertex} >= eff_count;
  assign depth_m2  = depth - DW'(2);

  // Unvisited neighbors in range, lowest one wins
  assign cand = adj_q & mask_q & ~visited;
  assign found = |cand;
  always_comb begin
    pick = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (cand[j]) pick = VERTEX_W'(j);
    end
  end

  always_comb begin
    state_next   = state;
    visited_next = visited;
    mask_next    = mask_q;
    depth_next   = depth;
    top_next     = top;
    pending_next = pending;
    out_load     = 1'b0;
    out_vertex   = pending;
    out_last     = 1'b0;
    out_bad      = 1'b0;
    adj_we       = 1'b0;
    adj_re       = 1'b0;
    stack_we     = 1'b0;
    stack_re     = 1'b0;
    adj_waddr    = row_index[AW-1:0];
    adj_raddr    = top[AW-1:0];
    stack_waddr  = depth[AW-1:0];
    stack_raddr  = depth_m2[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        if (item_take) begin
          if (opcode == OP_LOAD) begin
            adj_we = ({1'b0, row_index} < MAX_COUNT);
          end else begin
            visited_next = '0;
            depth_next   = '0;
            if (start_bad) begin
              out_load   = 1'b1;
              out_vertex = start_vertex;
              out_last   = 1'b1;
              out_bad    = 1'b1;
            end else begin
              for (int j = 0; j < ROW_W; j++) begin
                mask_next[j] = (COUNT_W'(j) < eff_count);
              end
              visited_next[start_vertex] = 1'b1;
              stack_we     = 1'b1;
              stack_waddr  = '0;
              depth_next   = DW'(1);
              top_next     = start_vertex;
              pending_next = start_vertex;
              state_next   = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        adj_re     = 1'b1;
        state_next = ST_PICK;
      end
      ST_PICK: begin
        // adj_q holds until the next read, so a stalled output just waits here
        if (out_free) begin
          if (found) begin
            out_load              = 1'b1;
            visited_next[pick]    = 1'b1;
            pending_next          = pick;
            top_next              = pick;
            if (depth < MAX_DEPTH) begin
              stack_we   = 1'b1;
              depth_next = depth + DW'(1);
            end
            state_next = ST_READ;
          end else if (depth == DW'(1)) begin
            out_load   = 1'b1;
            out_last   = 1'b1;
            depth_next = '0;
            state_next = ST_IDLE;
          end else begin
            // Pop: fetch the parent from the stack; pushes never hit this entry
            stack_re   = 1'b1;
            depth_next = depth - DW'(1);
            state_next = ST_POP;
          end
        end
      end
      ST_POP: begin
        top_next   = stack_q;
        adj_re     = 1'b1;
        adj_raddr  = stack_q[AW-1:0];
        state_next = ST_PICK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= row_bits;
    if (adj_re) adj_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= top_next;
    if (stack_re) stack_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= COUNT_RESET;
      visited      <= '0;
      depth        <= '0;
      result_valid <= 1'b0;
    end else begin
      state   <= state_next;
      visited <= visited_next;
      depth   <= depth_next;
      if (cfg_we) vertex_count <= cfg_wdata;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mask_q  <= mask_next;
    top     <= top_next;
    pending <= pending_next;
    if (out_load) begin
      visited_vertex <= out_vertex;
      last           <= out_last;
      bad_start      <= out_bad;
    end
  end

  // Checks
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= MAX_DEPTH)
    else $error("path stack depth above vertex limit");

  a_walk_has_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_PICK || state == ST_POP) |-> depth != '0)
    else $error("walk active with empty path stack");

  a_visit_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK && out_free && found) |=>
      $countones(visited) == $past($countones(visited)) + 1)
    else $error("visited map did not gain exactly one vertex");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bad_start) |-> last)
    else $error("bad start result without last mark");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK && out_free && !found && depth == DW'(1)) |=>
      (state == ST_IDLE && result_valid && last))
    else $error("walk end did not emit last result");

endmodule

>>> dv/tb_graph_depth_first_order.sv
`timescale 1ns / 1ps
// Testbench for graph_depth_first_order: random row loads and walks, checked against
// a self-contained depth-first walk predictor. Depends on gdfo_pkg and the block RTL.

import gdfo_pkg::*;

// One expected result of a walk
typedef struct packed {
  logic [VERTEX_W-1:0] vertex;
  logic                last;
  logic                bad_start;
} visit_rec_t;

// Holds a shadow of the adjacency rows and vertex_count, predicts each walk
// in recursive depth-first order and checks results in arrival order.
class visit_order_scoreboard;
  logic [ROW_W-1:0]   adj_rows [DEF_MAX_VERTICES];
  logic [COUNT_W-1:0] vcount;
  visit_rec_t         expected_visits [$];
  int                 fail_count;

  function new();
    vcount     = COUNT_RESET;
    fail_count = 0;
  endfunction

  function void set_vertex_count(logic [COUNT_W-1:0] value);
    vcount = value;
  endfunction

  task report(string msg);
    fail_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Called for every accepted request; a start queues the whole walk.
  function void note_request(opcode_t op, logic [VERTEX_W-1:0] idx,
                             logic [ROW_W-1:0] bits, logic [VERTEX_W-1:0] first);
    logic [ROW_W-1:0]    nbr_mask;
    logic [ROW_W-1:0]    seen;
    logic [ROW_W-1:0]    cand;
    logic [VERTEX_W-1:0] trail [DEF_MAX_VERTICES];
    logic [VERTEX_W-1:0] here;
    visit_rec_t          walk [$];
    visit_rec_t          rec;
    int                  depth;
    int                  span;
    int                  nxt;
    if (op == OP_LOAD) begin
      adj_rows[idx] = bits;
      return;
    end
    span = (vcount > 7'd64) ? 64 : int'(vcount);
    if (int'(first) >= span) begin
      rec = '{vertex: first, last: 1'b1, bad_start: 1'b1};
      expected_visits.push_back(rec);
      return;
    end
    nbr_mask = (span >= 64) ? '1 : ((64'd1 << span) - 64'd1);
    seen     = 64'd1 << first;
    trail[0] = first;
    depth    = 1;
    rec = '{vertex: first, last: 1'b0, bad_start: 1'b0};
    walk.push_back(rec);
    while (depth > 0) begin
      here = trail[depth-1];
      cand = adj_rows[here] & nbr_mask & ~seen;
      if (cand == '0) begin
        depth--;
      end else begin
        nxt = 0;
        while (cand[nxt] == 1'b0) nxt++;
        seen[nxt] = 1'b1;
        rec = '{vertex: VERTEX_W'(nxt), last: 1'b0, bad_start: 1'b0};
        walk.push_back(rec);
        trail[depth] = VERTEX_W'(nxt);
        depth++;
      end
    end
    while (walk.size() > 0) begin
      rec = walk.pop_front();
      rec.last = (walk.size() == 0);
      expected_visits.push_back(rec);
    end
  endfunction

  task check_visit(logic [VERTEX_W-1:0] vtx, logic lst, logic bad);
    visit_rec_t want;
    if (expected_visits.size() == 0) begin
      report($sformatf("unexpected result vertex=%0d last=%0b bad_start=%0b", vtx, lst, bad));
      return;
    end
    want = expected_visits.pop_front();
    if (vtx !== want.vertex)
      report($sformatf("visited_vertex got %0d want %0d", vtx, want.vertex));
    if (lst !== want.last)
      report($sformatf("last got %0b want %0b (vertex %0d)", lst, want.last, want.vertex));
    if (bad !== want.bad_start)
      report($sformatf("bad_start got %0b want %0b (vertex %0d)", bad, want.bad_start,
                       want.vertex));
  endtask
endclass

module tb_graph_depth_first_order;

  localparam int ITEM_TARGET  = 450;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Cycles to let pass after the last result before touching vertex_count;
  // the block returns to idle as it loads the last result.
  localparam int IDLE_SETTLE  = 8;

  // Row content styles; sparse and few-bit rows give trees, so walks backtrack.
  typedef enum int {
    SHAPE_EMPTY,
    SHAPE_FULL,
    SHAPE_DENSE,
    SHAPE_SPARSE,
    SHAPE_FEW,
    SHAPE_LOW
  } row_shape_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_stall;
  logic                opcode       = OP_LOAD;
  logic [VERTEX_W-1:0] row_index    = '0;
  logic [ROW_W-1:0]    row_bits     = '0;
  logic [VERTEX_W-1:0] start_vertex = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [VERTEX_W-1:0] visited_vertex;
  logic                last;
  logic                bad_start;
  logic                cfg_we       = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata    = '0;

  visit_order_scoreboard sb;

  int          sent_count  = 0;
  int          cycle_count = 0;
  // When set, that side runs flat out for the current phase
  bit          tx_no_gap   = 1'b0;
  bit          rx_no_gap   = 1'b0;
  logic [COUNT_W-1:0] cur_count = COUNT_RESET;

  graph_depth_first_order i_dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .opcode         (opcode),
    .row_index      (row_index),
    .row_bits       (row_bits),
    .start_vertex   (start_vertex),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .visited_vertex (visited_vertex),
    .last           (last),
    .bad_start      (bad_start),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("graph_depth_first_order verification failed");
      $finish;
    end
  end

  // Result monitor: sampled at the edge, so it sees the pre-edge values.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      sb.check_visit(visited_vertex, last, bad_start);
    end
  end

  // Receiver: per result, stall for a random hold, or not at all when rx_no_gap is set, before opening up.
  initial begin : rx_side
    int hold;
    forever begin
      hold = rx_no_gap ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (result_valid !== 1'b1) @(posedge clk);
    end
  end

  // Effective vertex count as the block should see it (0 allowed, saturates at 64)
  function automatic int span_of(logic [COUNT_W-1:0] value);
    return (value > 7'd64) ? 64 : int'(value);
  endfunction

  // Random row, biased toward shapes that make deep walks with backtracking
  function automatic logic [ROW_W-1:0] make_row(int span);
    logic [ROW_W-1:0] low_mask;
    logic [ROW_W-1:0] r;
    row_shape_t       shape;
    int               pick;
    int               reach;
    reach    = (span == 0) ? 64 : span;
    low_mask = (reach >= 64) ? '1 : ((64'd1 << reach) - 64'd1);
    pick     = $urandom_range(0, 9);
    if (pick < 1)      shape = SHAPE_EMPTY;
    else if (pick < 2) shape = SHAPE_FULL;
    else if (pick < 4) shape = SHAPE_DENSE;
    else if (pick < 6) shape = SHAPE_SPARSE;
    else if (pick < 9) shape = SHAPE_FEW;
    else               shape = SHAPE_LOW;
    case (shape)
      SHAPE_EMPTY:  r = '0;
      SHAPE_FULL:   r = '1;
      SHAPE_DENSE:  r = {$urandom, $urandom};
      SHAPE_SPARSE: r = {$urandom, $urandom} & {$urandom, $urandom}
                      & {$urandom, $urandom} & {$urandom, $urandom};
      // one or two in-range edges, garbage above the count that must be masked
      SHAPE_FEW:    r = ({$urandom, $urandom} & ~low_mask)
                      | (64'd1 << $urandom_range(0, reach - 1))
                      | (64'd1 << $urandom_range(0, reach - 1));
      default:      r = {$urandom, $urandom} & low_mask;
    endcase
    return r;
  endfunction

  // Present one request, hold it until accepted; valid stays high on return.
  task automatic send_request(opcode_t op, logic [VERTEX_W-1:0] idx,
                              logic [ROW_W-1:0] bits, logic [VERTEX_W-1:0] first);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    opcode       <= op;
    row_index    <= idx;
    row_bits     <= bits;
    start_vertex <= first;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    sb.note_request(op, idx, bits, first);
    sent_count++;
  endtask

  // Unused fields of each request carry random bits
  task automatic load_row(logic [VERTEX_W-1:0] idx, logic [ROW_W-1:0] bits);
    send_request(OP_LOAD, idx, bits, VERTEX_W'($urandom_range(0, 63)));
  endtask

  task automatic start_walk(logic [VERTEX_W-1:0] first);
    send_request(OP_START, VERTEX_W'($urandom_range(0, 63)), {$urandom, $urandom}, first);
  endtask

  // Sender goes quiet until every queued result is back, then lets the block settle.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_visits.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // vertex_count is only written with the block idle
  task automatic write_vertex_count(logic [COUNT_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_vertex_count(value);
    cur_count = value;
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_len;
    int span;
    int pick;
    logic [COUNT_W-1:0] next_count;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Every row gets written first so no walk ever reads an unloaded row.
    // Chain 0 -> 1 -> ... -> 63 gives the deepest possible path.
    for (int i = 0; i < DEF_MAX_VERTICES; i++) begin
      load_row(VERTEX_W'(i), (i == 63) ? '0 : (64'd1 << (i + 1)));
    end

    // Directed: full 64-deep walk at the reset count, then a lone vertex
    start_walk(6'd0);
    start_walk(6'd63);
    // all-ones row wraps back to vertex 0 and runs the whole chain
    load_row(6'd63, '1);
    start_walk(6'd63);
    // dead end at 0 after 63: long backtrack all the way to the start
    load_row(6'd0, '0);
    start_walk(6'd40);

    // Count below the row width: upper bits ignored, starts at/above count bad
    write_vertex_count(7'd10);
    start_walk(6'd5);
    start_walk(6'd10);
    start_walk(6'd63);
    // Count of zero: every start is bad
    write_vertex_count(7'd0);
    start_walk(6'd0);
    // Single vertex: full row masked down to nothing
    write_vertex_count(7'd1);
    load_row(6'd0, '1);
    start_walk(6'd0);
    start_walk(6'd1);
    // Counts above 64 saturate
    write_vertex_count(7'd127);
    load_row(6'd0, '0);
    start_walk(6'd62);
    write_vertex_count(7'd65);
    start_walk(6'd63);

    // Random phases, each under its own vertex_count and idling mix
    while (sent_count < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       next_count = 7'd0;
        1:       next_count = 7'd1;
        2:       next_count = 7'd2;
        3:       next_count = 7'd127;
        4:       next_count = 7'd64;
        5:       next_count = COUNT_W'($urandom_range(65, 127));
        default: next_count = COUNT_W'($urandom_range(3, 63));
      endcase
      write_vertex_count(next_count);
      tx_no_gap = ($urandom_range(0, 3) == 0);
      rx_no_gap = ($urandom_range(0, 3) == 0);
      span      = span_of(cur_count);
      phase_len = $urandom_range(15, 40);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 9) < 6) begin
          // most loads land inside the active vertex range so they shape the walks
          if (span > 0 && $urandom_range(0, 3) != 0)
            load_row(VERTEX_W'($urandom_range(0, span - 1)), make_row(span));
          else
            load_row(VERTEX_W'($urandom_range(0, 63)), make_row(span));
        end else begin
          if (span > 0 && $urandom_range(0, 9) < 8)
            start_walk(VERTEX_W'($urandom_range(0, span - 1)));
          else
            start_walk(VERTEX_W'($urandom_range(0, 63)));
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    while (sb.expected_visits.size() != 0) begin
      sb.report("expected result never arrived");
      void'(sb.expected_visits.pop_front());
    end
    if (sb.fail_count == 0) begin
      $display("graph_depth_first_order verification clean");
    end else begin
      $display("graph_depth_first_order verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/gdfo_pkg.sv
sv/graph_depth_first_order.sv
dv/tb_graph_depth_first_order.sv
